// ===== design/ttd_pkg.sv =====
// Shared types, constants and helpers for the tiled texture detiler.
// No dependencies; compiled first.
package ttd_pkg;

	// widths fixed by register and field definitions
	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int WALK_W    = 16;	// internal coordinate width before truncation
	localparam int CFG_IDX_W = 2;
	localparam int AR_DEPTH  = 16;
	localparam int AR_AW     = 4;

	// parameter defaults
	localparam int MAX_DIM_DEF   = 4096;
	localparam int PAL_DEPTH_DEF = 256;

	// request opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PAL   = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	// pixel formats
	localparam logic [1:0] FMT_CI4    = 2'd0;
	localparam logic [1:0] FMT_CI8    = 2'd1;
	localparam logic [1:0] FMT_RGBA32 = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// per-byte decode from the walker to the datapath
	typedef struct packed {
		logic               active;	// walk still inside the image, format known
		logic               rgba;
		logic               keep0;
		logic               keep1;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic               done0;
		logic               done1;
		logic               ar_we;
		logic               ar_hi;	// write A (high byte) rather than R
		logic [AR_AW-1:0]   ar_addr;
		logic               gh_we;	// capture green of a G,B pair
	} walk_t;

	// zero acts as 1, anything above the max acts as the max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== design/ttd_if.sv =====
// Handshake channels of the detiler: input requests, output pixels, config writes.
// Depends on ttd_pkg.
interface ttd_item_if import ttd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  pal_index;
	logic [31:0] pal_color;
	logic [7:0]  data_byte;

	modport source(output valid, opcode, pal_index, pal_color, data_byte, input ready);
	modport sink(input valid, opcode, pal_index, pal_color, data_byte, output ready);
endinterface

interface ttd_pixel_if import ttd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	logic               run_last;
	logic               image_done;

	modport source(output valid, pixel_x, pixel_y, red, green, blue, alpha, run_last,
		image_done, input ready);
	modport sink(input valid, pixel_x, pixel_y, red, green, blue, alpha, run_last,
		image_done, output ready);
endinterface

interface ttd_cfg_if import ttd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/ttd_pal_mem.sv =====
// Palette memory: one write port, two registered read ports (both CI4 nibbles).
// Depends on ttd_pkg.
module ttd_pal_mem import ttd_pkg::*; #(
	parameter int DEPTH = PAL_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [31:0]              rdata_a,
	output logic [31:0]              rdata_b
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// ===== design/ttd_ar_mem.sv =====
// Alpha/red buffer of one RGBA32 tile, written a byte at a time, one read port.
// Depends on ttd_pkg.
module ttd_ar_mem import ttd_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic             we_hi,
	input  logic [AR_AW-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [AR_AW-1:0] raddr,
	output logic [15:0]      rdata
);
	logic [15:0] mem [AR_DEPTH];

	// byte lanes avoid a read-modify-write
	always_ff @(posedge clk) begin
		if (we) begin
			if (we_hi) begin
				mem[waddr][15:8] <= wdata;
			end else begin
				mem[waddr][7:0] <= wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/ttd_walk.sv =====
// Tile walker: holds tile column, tile row and byte position, decodes one data byte
// into pixel positions and buffer controls. Depends on ttd_pkg.
module ttd_walk import ttd_pkg::*; #(
	parameter int MAX_DIM       = MAX_DIM_DEF,
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic [1:0]       fmt,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	input  logic [7:0]       data_byte,
	output walk_t            walk
);
	logic [COORD_W-1:0] tcol_q, trow_q;
	logic [5:0]         bit_q;

	logic [DIM_W-1:0]   w, h;
	logic [WALK_W-1:0]  w16, h16, row_base, col_base, x0, x1, y0, next_base;
	logic [COORD_W-1:0] tcol_inc;
	logic [5:0]         b, n0;
	logic [2:0]         col0, row0;
	logic               is_rgba, is_ci4, is_ci8, fmt_ok, idx_ok, in0, in1, last, wrap;

	always_comb begin
		w        = clamp_dim(width, DIM_W'(MAX_DIM));
		h        = clamp_dim(height, DIM_W'(MAX_DIM));
		w16      = WALK_W'(w);
		h16      = WALK_W'(h);
		is_ci4   = (fmt == FMT_CI4);
		is_ci8   = (fmt == FMT_CI8);
		is_rgba  = (fmt == FMT_RGBA32);
		fmt_ok   = fmt inside {FMT_CI4, FMT_CI8, FMT_RGBA32};

		// tile is 8 wide for CI formats, 4 for RGBA32; 8 tall only for CI4
		row_base = is_ci4 ? {1'b0, trow_q, 3'b0} : {2'b0, trow_q, 2'b0};
		col_base = is_rgba ? {2'b0, tcol_q, 2'b0} : {1'b0, tcol_q, 3'b0};
		b        = is_rgba ? bit_q : {1'b0, bit_q[4:0]};

		if (is_ci4) begin
			n0 = {b[4:0], 1'b0};
		end else if (is_rgba) begin
			n0 = {2'b0, b[4:1]};
		end else begin
			n0 = {1'b0, b[4:0]};
		end
		col0 = is_rgba ? {1'b0, n0[1:0]} : n0[2:0];
		row0 = is_rgba ? {1'b0, n0[3:2]} : n0[5:3];

		x0     = col_base + WALK_W'(col0);
		x1     = {x0[WALK_W-1:1], 1'b1};	// second CI4 pixel, same row
		y0     = row_base + WALK_W'(row0);
		in0    = (x0 < w16) && (y0 < h16);
		in1    = (x1 < w16) && (y0 < h16);
		idx_ok = !is_ci8 || ({1'b0, data_byte} < 9'(PALETTE_DEPTH));

		last      = is_rgba ? (b == 6'd63) : (b[4:0] == 5'd31);
		tcol_inc  = tcol_q + 1'b1;
		next_base = is_rgba ? {2'b0, tcol_inc, 2'b0} : {1'b0, tcol_inc, 3'b0};
		wrap      = next_base >= w16;

		walk.active  = fmt_ok && (row_base < h16);
		walk.rgba    = is_rgba;
		walk.keep0   = in0 && idx_ok && (!is_rgba || (b[5] && b[0]));
		walk.keep1   = is_ci4 && in1;
		walk.x0      = x0[COORD_W-1:0];
		walk.x1      = x1[COORD_W-1:0];
		walk.y0      = y0[COORD_W-1:0];
		walk.done0   = (x0 == w16 - 1'b1) && (y0 == h16 - 1'b1);
		walk.done1   = (x1 == w16 - 1'b1) && (y0 == h16 - 1'b1);
		walk.ar_we   = is_rgba && !b[5];
		walk.ar_hi   = !b[0];
		walk.ar_addr = b[4:1];
		walk.gh_we   = is_rgba && b[5] && !b[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcol_q <= '0;
			trow_q <= '0;
			bit_q  <= '0;
		end else if (start) begin
			tcol_q <= '0;
			trow_q <= '0;
			bit_q  <= '0;
		end else if (step && walk.active) begin
			if (last) begin
				bit_q <= '0;
				if (wrap) begin
					tcol_q <= '0;
					trow_q <= trow_q + 1'b1;
				end else begin
					tcol_q <= tcol_inc;
				end
			end else begin
				bit_q <= b + 1'b1;
			end
		end
	end
endmodule

// ===== design/tiled_texture_detiler.sv =====
// Tiled texture detiler: turns palette writes and tile-ordered CI4, CI8 or RGBA32
// texture bytes into linear pixels (x, y, RGBA). Depends on ttd_pkg, ttd_if,
// ttd_walk, ttd_pal_mem and ttd_ar_mem.
//
// Usage: write pixel_format, image_width and image_height over cfg while idle,
// load the palette with opcode 1 requests, send a start request, then stream the
// texture bytes. Each byte is decoded in the cycle it is accepted: the walker
// gives pixel positions, the palette is read at both CI4 nibbles through two read
// ports and the alpha/red buffer is read, or written a byte lane at a time. In the
// next cycle the kept pixels sit in the pixel stage and leave through a registered
// output stage, one pixel per cycle while the output is ready. A CI4 byte that
// keeps both pixels holds the pixel stage for two hand-offs, since the output
// channel carries one pixel per cycle; the next byte waits for both. Padding
// pixels beyond the image are dropped and bytes past the last tile row are
// swallowed until the next start. Memories need no clearing after reset: reading
// a never-written palette or alpha/red entry yields unspecified color.
module tiled_texture_detiler import ttd_pkg::*; #(
	parameter int MAX_DIM       = MAX_DIM_DEF,
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ttd_item_if.sink     item,
	ttd_pixel_if.source  pixel,
	ttd_cfg_if.sink      cfg
);
	localparam int PAW = $clog2(PALETTE_DEPTH);

	// configuration registers
	logic [1:0]       fmt_q;
	logic [DIM_W-1:0] width_q, height_q;

	// request decode
	logic  acc, start, step, go, pal_we, load;
	walk_t walk;

	// memory read data
	logic [31:0] pal_a, pal_b;
	logic [15:0] ar_rd;
	logic [7:0]  green_hold_q;

	// pixel stage: up to two kept pixels of one byte
	logic [1:0]         kvec_s1;
	logic [COORD_W-1:0] x0_s1, x1_s1, y_s1;
	logic               done0_s1, done1_s1, rgba_s1;
	logic [7:0]         g_s1, b_s1;
	logic               s1_valid, sel, s2_free, s1_move, s1_last;
	logic [31:0]        pal_sel;

	// output stage
	logic               out_valid_q, run_last_q, done_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic [7:0]         red_q, green_q, blue_q, alpha_q;

	logic [DIM_W-1:0] w_eff, h_eff;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_CI4;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FORMAT: fmt_q    <= cfg.data[1:0];
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- accept and decode ----------------
	assign acc    = item.valid && item.ready;
	assign start  = acc && (item.opcode == OP_START);
	assign step   = acc && (item.opcode == OP_DATA);
	assign go     = step && walk.active;
	assign pal_we = acc && (item.opcode == OP_PAL) &&
		({1'b0, item.pal_index} < 9'(PALETTE_DEPTH));
	assign load   = go && (walk.keep0 || walk.keep1);

	ttd_walk #(
		.MAX_DIM       (MAX_DIM),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.step      (step),
		.fmt       (fmt_q),
		.width     (width_q),
		.height    (height_q),
		.data_byte (item.data_byte),
		.walk      (walk)
	);

	// A write lands at its accept edge and a read is issued no earlier than the
	// next accept, so palette and alpha/red accesses never need forwarding.
	// Port A: CI4 high nibble or CI8 index. Port B: CI4 low nibble.
	ttd_pal_mem #(
		.DEPTH (PALETTE_DEPTH)
	) u_pal (
		.clk     (clk),
		.we      (pal_we),
		.waddr   (PAW'(item.pal_index)),
		.wdata   (item.pal_color),
		.re      (go),
		.raddr_a ((fmt_q == FMT_CI4) ? PAW'(item.data_byte[7:4]) : PAW'(item.data_byte)),
		.raddr_b (PAW'(item.data_byte[3:0])),
		.rdata_a (pal_a),
		.rdata_b (pal_b)
	);

	// first half of an RGBA32 tile fills A,R; second half reads it back per pixel
	ttd_ar_mem u_ar (
		.clk   (clk),
		.we    (go && walk.ar_we),
		.we_hi (walk.ar_hi),
		.waddr (walk.ar_addr),
		.wdata (item.data_byte),
		.re    (go),
		.raddr (walk.ar_addr),
		.rdata (ar_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_hold_q <= '0;
		end else if (go && walk.gh_we) begin
			green_hold_q <= item.data_byte;
		end
	end

	// ---------------- pixel stage ----------------
	// Memory read data stays put until the next decoded byte, which can only be
	// accepted at the edge where this stage hands off its last pixel.
	assign s1_valid = |kvec_s1;
	assign sel      = !kvec_s1[0];
	assign s2_free  = !out_valid_q || pixel.ready;
	assign s1_move  = s1_valid && s2_free;
	assign s1_last  = $onehot(kvec_s1);
	assign pal_sel  = sel ? pal_b : pal_a;

	// a new request is taken when the pixel stage is empty or hands off its last pixel
	assign item.ready = !s1_valid || (s1_move && s1_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvec_s1 <= '0;
		end else if (load) begin
			kvec_s1 <= {walk.keep1, walk.keep0};
		end else if (s1_move) begin
			kvec_s1 <= sel ? (kvec_s1 & 2'b01) : (kvec_s1 & 2'b10);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x0_s1    <= walk.x0;
			x1_s1    <= walk.x1;
			y_s1     <= walk.y0;
			done0_s1 <= walk.done0;
			done1_s1 <= walk.done1;
			rgba_s1  <= walk.rgba;
			g_s1     <= green_hold_q;
			b_s1     <= item.data_byte;
		end
	end

	// ---------------- output stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_x_q    <= sel ? x1_s1 : x0_s1;
			out_y_q    <= y_s1;
			done_q     <= sel ? done1_s1 : done0_s1;
			run_last_q <= s1_last;
			if (rgba_s1) begin
				red_q   <= ar_rd[7:0];
				green_q <= g_s1;
				blue_q  <= b_s1;
				alpha_q <= ar_rd[15:8];
			end else begin
				red_q   <= pal_sel[31:24];
				green_q <= pal_sel[23:16];
				blue_q  <= pal_sel[15:8];
				alpha_q <= pal_sel[7:0];
			end
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.pixel_x    = out_x_q;
	assign pixel.pixel_y    = out_y_q;
	assign pixel.red        = red_q;
	assign pixel.green      = green_q;
	assign pixel.blue       = blue_q;
	assign pixel.alpha      = alpha_q;
	assign pixel.run_last   = run_last_q;
	assign pixel.image_done = done_q;

	// ---------------- assertions ----------------
	assign w_eff = clamp_dim(width_q, DIM_W'(MAX_DIM));
	assign h_eff = clamp_dim(height_q, DIM_W'(MAX_DIM));

	// the corner pixel is always the last one its byte produces
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.image_done |-> pixel.run_last)
		else $error("image_done without run_last");

	// a CI4 pair leaves high nibble first, low nibble stays
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && (kvec_s1 == 2'b11) |=> (kvec_s1 == 2'b10))
		else $error("pixel pair handed off out of order");

	// no request may land on a stage still holding two pixels
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(kvec_s1 == 2'b11) |-> !item.ready)
		else $error("request accepted over a full pixel stage");

	// padding never escapes
	a_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid |-> ({1'b0, pixel.pixel_x} < w_eff) && ({1'b0, pixel.pixel_y} < h_eff))
		else $error("pixel outside the image");
endmodule
